// ----- sv/qpht_pkg.sv -----
// Shared constants and types for the quadratic-probing hash table.
// No dependencies; used by qpht_mod and the top level.
`default_nettype none

package qpht_pkg;

  localparam int TABLE_SIZE_DEF = 1021;
  localparam int KEY_WIDTH_DEF  = 32;

  localparam int KEY_IN_W = 32;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;

  // Key bits folded into the remainder per step.
  localparam int DIGIT_W = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_PRESENT   = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- sv/qpht_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module qpht_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1021
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/qpht_mod.sv -----
// Key-modulo-table-size unit: per DIGIT_W key digit, MSB first, one reciprocal
// multiply and one multiply-subtract, each registered. Depends on qpht_pkg.
`default_nettype none

module qpht_mod #(
  parameter int MODULUS   = qpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_WIDTH = qpht_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [KEY_WIDTH-1:0]       key_i,
  output logic                            done_o,
  output logic [$clog2(MODULUS)-1:0]      rem_o
);

  localparam int DW     = qpht_pkg::DIGIT_W;
  localparam int SW     = $clog2(MODULUS);
  localparam int XW     = SW + DW;
  localparam int RW     = XW + 1;
  localparam int PW     = 2 * XW;
  localparam int SHIFT  = XW + SW;
  localparam int DIGITS = (KEY_WIDTH + DW - 1) / DW;
  localparam int PAD_W  = DIGITS * DW;
  localparam int NW     = $clog2(DIGITS + 1);
  localparam logic [63:0]   POW2  = 64'd1 << SHIFT;
  localparam logic [RW-1:0] RECIP = RW'((POW2 + 64'(MODULUS) - 64'd1) / 64'(MODULUS));

  logic             busy_q;
  logic             phase_q;
  logic             done_q;
  logic [NW-1:0]    cnt_q;
  logic [PAD_W-1:0] sh_q;
  logic [XW-1:0]    x_q;
  logic [DW-1:0]    quo_q;
  logic [SW-1:0]    rem_q;

  logic [PAD_W-1:0] key_pad;
  logic [PW-1:0]    prod;
  logic [XW-1:0]    quo_m;
  logic [XW-1:0]    diff;
  logic [SW-1:0]    rem_d;

  assign key_pad = PAD_W'(key_i);
  assign prod    = PW'(x_q) * PW'(RECIP);
  assign quo_m   = XW'(quo_q) * XW'(MODULUS);
  assign diff    = x_q - quo_m;
  assign rem_d   = diff[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      sh_q    <= '0;
      x_q     <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= NW'(DIGITS);
        sh_q    <= key_pad << DW;
        x_q     <= XW'(key_pad[PAD_W-1 -: DW]);
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (!phase_q) begin
          quo_q <= prod[PW-1 -: DW];
        end else begin
          cnt_q <= cnt_q - NW'(1);
          if (cnt_q == NW'(1)) begin
            rem_q  <= rem_d;
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            x_q  <= {rem_d, sh_q[PAD_W-1 -: DW]};
            sh_q <= sh_q << DW;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- sv/quadratic_probe_hash_table.sv -----
// Quadratic-probing hash set: top level with probe sequencer and slot memory.
// Depends on qpht_pkg, qpht_ram and qpht_mod.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: mode_i
//   (0 find, 1 insert if absent) and key_i. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result per request: slot_o, status_o
//   (0 present, 1 empty slot reached, 2 probes exhausted), probe_count_o.
//   A transfer happens on a rising edge where valid is high and stall is low.
//   Sequence: the modulo unit computes the home slot with a reciprocal multiply
//   and a multiply-subtract, each registered, per 16-bit key digit, MSB first;
//   then each probe is one read of the slot memory. Requests are handled one
//   at a time: in_stall_o stays high from acceptance until the result is
//   loaded into the output register.
//   The memory read port sets the one-probe-per-cycle pace.
//   Reset: after rst_ni releases, a clearing pass of TABLE_SIZE cycles marks
//   every slot empty; in_stall_o stays high meanwhile.
//   Stall: the result sits in an output register; the next request is still
//   accepted, and a finished probe holds until that register is free.
`default_nettype none

module quadratic_probe_hash_table #(
  parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = qpht_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [qpht_pkg::KEY_IN_W-1:0] key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [qpht_pkg::SLOT_W-1:0]        slot_o,
  output logic [qpht_pkg::STATUS_W-1:0]      status_o,
  output logic [qpht_pkg::COUNT_W-1:0]       probe_count_o
);

  localparam int SW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int EW = KEY_WIDTH + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_e;

  state_e                       state_q;
  logic [SW-1:0]                clr_q;
  logic                         mode_q;
  logic [KEY_WIDTH-1:0]         key_q;
  logic [SW-1:0]                pos_q;
  logic [SW-1:0]                step_q;
  logic [CW-1:0]                hits_q;
  logic                         out_valid_q;
  logic [qpht_pkg::SLOT_W-1:0]  slot_q;
  qpht_pkg::status_e            status_q;
  logic [qpht_pkg::COUNT_W-1:0] count_q;

  logic                 accept;
  logic [KEY_WIDTH-1:0] key_w;
  logic                 mod_done;
  logic [SW-1:0]        home;

  logic                 rd_en;
  logic [SW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic                 wr_en;
  logic [SW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  logic                 ent_valid;
  logic                 hit;
  logic [CW-1:0]        hits_inc;
  logic                 exhaust;
  logic                 finish;
  logic                 out_free;
  logic                 load_out;
  logic [SW:0]          pos_sum;
  logic [SW-1:0]        pos_d;
  logic [SW:0]          step_sum;
  logic [SW-1:0]        step_d;
  qpht_pkg::status_e    status_d;

  assign key_w  = KEY_WIDTH'(key_i);
  assign accept = in_valid_i && (state_q == S_IDLE);

  qpht_mod #(
    .MODULUS   (TABLE_SIZE),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_w),
    .done_o  (mod_done),
    .rem_o   (home)
  );

  assign ent_valid = rd_data[KEY_WIDTH];
  assign hit       = ent_valid && (rd_data[KEY_WIDTH-1:0] == key_q);
  assign hits_inc  = hits_q + CW'(1);
  assign exhaust   = (hits_inc == CW'(TABLE_SIZE));
  assign finish    = !ent_valid || hit || exhaust;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == S_PROBE) && finish && out_free;

  // Next position and next step (step grows by 2, reduced modulo TABLE_SIZE), both kept below TABLE_SIZE.
  assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_d    = (pos_sum >= (SW+1)'(TABLE_SIZE)) ?
                    SW'(pos_sum - (SW+1)'(TABLE_SIZE)) : SW'(pos_sum);
  assign step_sum = {1'b0, step_q} + (SW+1)'(2);
  assign step_d   = (step_sum >= (SW+1)'(TABLE_SIZE)) ?
                    SW'(step_sum - (SW+1)'(TABLE_SIZE)) : SW'(step_sum);

  always_comb begin
    priority if (!ent_valid) begin
      status_d = qpht_pkg::ST_EMPTY;
    end else if (hit) begin
      status_d = qpht_pkg::ST_PRESENT;
    end else begin
      status_d = qpht_pkg::ST_EXHAUSTED;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_d;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = {1'b1, key_q};
    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      S_HASH: begin
        rd_en   = mod_done;
        rd_addr = home;
      end
      S_PROBE: begin
        rd_en = !finish;
        wr_en = finish && out_free && !ent_valid && mode_q;
      end
      default: begin
      end
    endcase
  end

  qpht_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mode_q      <= 1'b0;
      key_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      status_q    <= qpht_pkg::ST_PRESENT;
      count_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(TABLE_SIZE - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            mode_q  <= mode_i;
            key_q   <= key_w;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            pos_q   <= home;
            step_q  <= SW'(1);
            hits_q  <= '0;
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!finish) begin
            pos_q  <= pos_d;
            step_q <= step_d;
            hits_q <= hits_inc;
          end else if (out_free) begin
            // Load the result and release the sequencer.
            out_valid_q <= 1'b1;
            slot_q      <= qpht_pkg::SLOT_W'(pos_q);
            status_q    <= status_d;
            count_q     <= (!ent_valid || hit) ? qpht_pkg::COUNT_W'(hits_q)
                                               : qpht_pkg::COUNT_W'(hits_inc);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign slot_o        = slot_q;
  assign status_o      = status_q;
  assign probe_count_o = count_q;

endmodule

`default_nettype wire
